@@ rtl/core/fhd_pkg.sv @@
// Shared types, constants and helpers for the frame header decoder.
package fhd_pkg;

   // Header layout
   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned POS_W        = 4;
   localparam logic [POS_W-1:0] POS_MAJOR    = 4'd4;
   localparam logic [POS_W-1:0] POS_MINOR    = 4'd5;
   localparam logic [POS_W-1:0] POS_KIND     = 4'd8;
   localparam logic [POS_W-1:0] POS_FLAGS    = 4'd10;
   localparam logic [POS_W-1:0] POS_PAYLOAD  = 4'd12;
   localparam logic [POS_W-1:0] POS_LAST     = 4'd15;
   localparam logic [15:0]      HEADER_SIZE_GOOD = 16'd16;

   // Magic bytes
   localparam logic [7:0] MAGIC_P = 8'h50;
   localparam logic [7:0] MAGIC_A = 8'h41;
   localparam logic [7:0] MAGIC_C = 8'h43;

   // Queue depth between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // Register reset values
   localparam logic [31:0] MAX_PAYLOAD_RESET    = 32'hFFFF_FFFF;
   localparam logic [7:0]  EXPECTED_MAJOR_RESET = 8'd1;
   localparam logic [7:0]  EXPECTED_MINOR_RESET = 8'd0;

   // Register indexes (byte address = 4 * index)
   localparam int unsigned CSR_ADDR_W = 4;
   typedef enum logic [1:0] {
      CSR_MAX_PAYLOAD    = 2'd0,
      CSR_EXPECTED_MAJOR = 2'd1,
      CSR_EXPECTED_MINOR = 2'd2
   } csr_index_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_NOT_SUPPORTED = 2'd1,
      ST_PROTOCOL      = 2'd2,
      ST_LIMIT         = 2'd3
   } status_type;

   // Configuration seen by the back end
   typedef struct packed {
      logic [31:0] max_payload;
      logic [7:0]  expected_major;
      logic [7:0]  expected_minor;
   } cfg_type;

   // One collected header, handed from front to back
   typedef struct packed {
      logic        early_end;
      logic        magic_good;
      logic [7:0]  major;
      logic [7:0]  minor;
      logic [15:0] header_size;
      logic [15:0] kind;
      logic [15:0] flags;
      logic [31:0] payload;
   } job_type;

   // Queue status toward front end and checks
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Expected magic byte for positions 0..3
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = MAGIC_P;
         2'd1:    val = MAGIC_A;
         default: val = MAGIC_C;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/fhd_csr.sv @@
// Configuration registers behind the APB-style port.
module fhd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fhd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output fhd_pkg::cfg_type                cfg
);
   import fhd_pkg::*;

   logic [31:0] max_payload_ff;
   logic [7:0]  expected_major_ff;
   logic [7:0]  expected_minor_ff;
   logic        write_en;
   csr_index_type index;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite & pready;
   assign index    = csr_index_type'(paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff    <= MAX_PAYLOAD_RESET;
         expected_major_ff <= EXPECTED_MAJOR_RESET;
         expected_minor_ff <= EXPECTED_MINOR_RESET;
      end else if (write_en) begin
         case (index)
            CSR_MAX_PAYLOAD:    max_payload_ff    <= pwdata;
            CSR_EXPECTED_MAJOR: expected_major_ff <= pwdata[7:0];
            CSR_EXPECTED_MINOR: expected_minor_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (index)
         CSR_MAX_PAYLOAD:    prdata = max_payload_ff;
         CSR_EXPECTED_MAJOR: prdata = {24'd0, expected_major_ff};
         CSR_EXPECTED_MINOR: prdata = {24'd0, expected_minor_ff};
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg.max_payload    = max_payload_ff;
   assign cfg.expected_major = expected_major_ff;
   assign cfg.expected_minor = expected_minor_ff;

endmodule

@@ rtl/core/fhd_front.sv @@
// Front end: takes header bytes, tracks position and collects fields.
module fhd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             frame_start,
   input  logic             end_of_input,
   output logic             push,
   output fhd_pkg::job_type job
);
   import fhd_pkg::*;

   logic [POS_W-1:0] count_ff, count_in;
   logic             magic_good_ff, magic_good_in;
   logic             finished_ff, finished_in;
   logic [7:0]       major_ff, major_in;
   logic [7:0]       minor_ff, minor_in;
   logic [15:0]      hsize_ff, hsize_in;
   logic [15:0]      kind_ff, kind_in;
   logic [15:0]      flags_ff, flags_in;
   logic [23:0]      pay_ff, pay_in;

   logic [POS_W-1:0] pos;
   logic             magic_eff;
   logic             finished_eff;

   // a start mark restarts collection on this very word
   assign pos          = frame_start ? '0 : count_ff;
   assign magic_eff    = frame_start ? 1'b1 : magic_good_ff;
   assign finished_eff = frame_start ? 1'b0 : finished_ff;

   always_comb begin
      count_in      = count_ff;
      magic_good_in = magic_good_ff;
      finished_in   = finished_ff;
      major_in      = major_ff;
      minor_in      = minor_ff;
      hsize_in      = hsize_ff;
      kind_in       = kind_ff;
      flags_in      = flags_ff;
      pay_in        = pay_ff;
      push          = 1'b0;

      if (accept) begin
         count_in      = pos;
         magic_good_in = magic_eff;
         finished_in   = finished_eff;
         if (!finished_eff) begin
            // capture the byte by position
            if (pos < POS_MAJOR) begin
               if (data_byte != magic_byte(pos[1:0]))
                  magic_good_in = 1'b0;
            end else if (pos == POS_MAJOR) begin
               major_in = data_byte;
            end else if (pos == POS_MINOR) begin
               minor_in = data_byte;
            end else if (pos < POS_KIND) begin
               hsize_in = {hsize_ff[7:0], data_byte};
            end else if (pos < POS_FLAGS) begin
               kind_in = {kind_ff[7:0], data_byte};
            end else if (pos < POS_PAYLOAD) begin
               flags_in = {flags_ff[7:0], data_byte};
            end else if (pos < POS_LAST) begin
               pay_in = {pay_ff[15:0], data_byte};
            end

            if (pos == POS_LAST) begin
               finished_in = 1'b1;
               push        = 1'b1;
            end else begin
               count_in = pos + 1'b1;
               if (end_of_input) begin
                  finished_in = 1'b1;
                  push        = 1'b1;
               end
            end
         end
      end
   end

   // job word for the queue
   assign job.early_end   = (pos != POS_LAST);
   assign job.magic_good  = magic_eff;
   assign job.major       = major_ff;
   assign job.minor       = minor_ff;
   assign job.header_size = hsize_ff;
   assign job.kind        = kind_ff;
   assign job.flags       = flags_ff;
   assign job.payload     = {pay_ff, data_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         magic_good_ff <= 1'b1;
         finished_ff   <= 1'b0;
         major_ff      <= '0;
         minor_ff      <= '0;
         hsize_ff      <= '0;
         kind_ff       <= '0;
         flags_ff      <= '0;
         pay_ff        <= '0;
      end else begin
         count_ff      <= count_in;
         magic_good_ff <= magic_good_in;
         finished_ff   <= finished_in;
         major_ff      <= major_in;
         minor_ff      <= minor_in;
         hsize_ff      <= hsize_in;
         kind_ff       <= kind_in;
         flags_ff      <= flags_in;
         pay_ff        <= pay_in;
      end
   end

endmodule

@@ rtl/core/fhd_queue.sv @@
// Short queue of collected headers between front and back.
module fhd_queue #(
   parameter int unsigned DEPTH = fhd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fhd_pkg::job_type          push_job,
   input  logic                      pop,
   output fhd_pkg::job_type          head_job,
   output fhd_pkg::queue_status_type status
);
   import fhd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

@@ rtl/core/fhd_back.sv @@
// Back end: runs the header checks and holds the result word.
module fhd_back (
   input  logic             clock,
   input  logic             reset,
   input  fhd_pkg::cfg_type cfg,
   input  logic             job_ready,
   input  fhd_pkg::job_type job,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_major_version,
   output logic [7:0]       rsp_minor_version,
   output logic [15:0]      rsp_header_size,
   output logic [15:0]      rsp_message_kind,
   output logic [15:0]      rsp_flag_bits,
   output logic [31:0]      rsp_payload_size
);
   import fhd_pkg::*;

   logic        valid_ff, valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  major_ff, minor_ff;
   logic [15:0] hsize_ff, kind_ff, flags_ff;
   logic [31:0] pay_ff;
   logic        zero_fields;

   // take a job when the output register is free or being drained
   assign pop = job_ready & (~valid_ff | ~rsp_stall);

   // checks in priority order
   always_comb begin
      if (job.early_end)
         status_in = ST_LIMIT;
      else if (!job.magic_good)
         status_in = ST_PROTOCOL;
      else if (job.major != cfg.expected_major || job.minor != cfg.expected_minor)
         status_in = ST_NOT_SUPPORTED;
      else if (job.header_size != HEADER_SIZE_GOOD || job.kind == '0 || job.flags != '0)
         status_in = ST_PROTOCOL;
      else if (job.payload > cfg.max_payload)
         status_in = ST_LIMIT;
      else
         status_in = ST_OK;
   end

   assign zero_fields = (status_in != ST_OK);

   always_comb begin
      valid_in = valid_ff;
      if (pop)
         valid_in = 1'b1;
      else if (valid_ff && !rsp_stall)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   // result payload, errors carry zero fields
   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         major_ff  <= zero_fields ? '0 : job.major;
         minor_ff  <= zero_fields ? '0 : job.minor;
         hsize_ff  <= zero_fields ? '0 : job.header_size;
         kind_ff   <= zero_fields ? '0 : job.kind;
         flags_ff  <= zero_fields ? '0 : job.flags;
         pay_ff    <= zero_fields ? '0 : job.payload;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_major_version = major_ff;
   assign rsp_minor_version = minor_ff;
   assign rsp_header_size   = hsize_ff;
   assign rsp_message_kind  = kind_ff;
   assign rsp_flag_bits     = flags_ff;
   assign rsp_payload_size  = pay_ff;

endmodule

@@ rtl/core/frame_header_decoder_core.sv @@
// Top level of the frame header decoder: front, queue, back and registers.
//
// Input channel (req_): one header byte per word with frame_start and
// end_of_input marks. A word is taken when req_valid is high and req_stall
// is low; one byte per cycle is sustained while not stalled. req_stall
// rises only while the header queue is full, i.e. after the result side
// has stalled long enough.
// Result channel (rsp_): one word per finished header (16th byte) or per
// early end of input, taken when rsp_valid is high and rsp_stall is low.
// A held word keeps its value while stalled; the next header keeps being
// collected and queued behind it.
// The edge that takes the last byte writes the job into the front-to-back
// queue; it then loads the output register, and so the rsp_ ports, once
// that register is free or being drained.
// Throughput is one result per cycle out of the queue while not stalled.
// Registers: max_payload at 0x0, expected_major at 0x4, expected_minor at
// 0x8; write them only while the block is idle. Reset clears the byte
// position and queue, drops any pending result and loads the register defaults; collection is open right after reset.
module frame_header_decoder_core #(
   parameter int unsigned QUEUE_DEPTH = fhd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_frame_start,
   input  logic                           req_end_of_input,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [7:0]                     rsp_major_version,
   output logic [7:0]                     rsp_minor_version,
   output logic [15:0]                    rsp_header_size,
   output logic [15:0]                    rsp_message_kind,
   output logic [15:0]                    rsp_flag_bits,
   output logic [31:0]                    rsp_payload_size,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fhd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import fhd_pkg::*;

   cfg_type          cfg;
   job_type          push_job, head_job;
   queue_status_type queue_status;
   logic             req_accept;
   logic             push, pop;

   assign req_stall  = queue_status.full;
   assign req_accept = req_valid & ~req_stall;

   fhd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fhd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_data_byte),
      .frame_start  (req_frame_start),
      .end_of_input (req_end_of_input),
      .push         (push),
      .job          (push_job)
   );

   fhd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   fhd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .job_ready         (~queue_status.empty),
      .job               (head_job),
      .pop               (pop),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_major_version (rsp_major_version),
      .rsp_minor_version (rsp_minor_version),
      .rsp_header_size   (rsp_header_size),
      .rsp_message_kind  (rsp_message_kind),
      .rsp_flag_bits     (rsp_flag_bits),
      .rsp_payload_size  (rsp_payload_size)
   );

   // the front never queues a header into a full queue
   assert property (@(posedge clock) disable iff (reset) !(push && queue_status.full))
      else $error("header pushed into full queue");

   // no result word survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // error results carry zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_major_version == '0 && rsp_minor_version == '0 && rsp_header_size == '0 &&
          rsp_message_kind == '0 && rsp_flag_bits == '0 && rsp_payload_size == '0))
      else $error("error result with nonzero fields");

   // a good result passed the layout checks
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |->
         (rsp_header_size == HEADER_SIZE_GOOD && rsp_message_kind != '0 &&
          rsp_flag_bits == '0))
      else $error("good result with bad layout fields");

endmodule
